// File: rtl/dnv_pkg.sv
// Shared types, constants and helper functions for the DNS name validator.
// No dependencies; every other source file but dnv_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dnv_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME = 8'd1;

    localparam logic [CFG_DATA_W-1:0] MAX_LABEL_RST = 8'd63;
    localparam logic [CFG_DATA_W-1:0] MAX_NAME_RST = 8'd255;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    typedef enum logic [1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_NON_RFC  = 2'd1,
        STATUS_BAD_CHAR = 2'd2,
        STATUS_INVALID  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       byte_present;
        logic       end_of_name;
    } in_item_t;

    typedef struct packed {
        logic             step;
        logic             load_result;
    } stage_ctl_t;

    typedef struct packed {
        logic [1:0]       trail_left;
        logic [CNT_W-1:0] label_bytes;
        logic [CNT_W-1:0] name_bytes;
        logic             fatal_seen;
        logic             bad_char_seen;
        logic             non_rfc_seen;
        logic             first_was_dot;
    } name_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CHAR_HYPHEN};
    endfunction

endpackage

`default_nettype wire

// File: rtl/dnv_cfg_regs.sv
// Configuration registers: label and name length limits.
// Depends on dnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnv_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dnv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dnv_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [dnv_pkg::CFG_DATA_W-1:0]      max_label,
    output logic [dnv_pkg::CFG_DATA_W-1:0]      max_name
);
    import dnv_pkg::*;

    logic [CFG_DATA_W-1:0] max_label_reg;
    logic [CFG_DATA_W-1:0] max_name_reg;
    logic                  wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_reg <= MAX_LABEL_RST;
            max_name_reg  <= MAX_NAME_RST;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                CFG_MAX_LABEL: max_label_reg <= cfg_data;
                CFG_MAX_NAME:  max_name_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign max_label = max_label_reg;
    assign max_name  = max_name_reg;

endmodule

`default_nettype wire

// File: rtl/dnv_in_stage.sv
// Input register stage: holds one request and issues it to the core.
// Depends on dnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnv_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire dnv_pkg::in_item_t in_item,
    input  wire logic              out_busy,
    output dnv_pkg::in_item_t      item,
    output dnv_pkg::stage_ctl_t    ctl
);
    import dnv_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;
    logic     step;
    logic     accept;

    // an item that ends a name needs a free result register
    assign step = vld_reg && !(item_reg.end_of_name && out_busy);
    assign in_stall = vld_reg && !step;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (step)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item = item_reg;
    assign ctl.step = step;
    assign ctl.load_result = step && item_reg.end_of_name;

endmodule

`default_nettype wire

// File: rtl/dnv_core.sv
// Per-name state (UTF-8 trail count, counters, sticky flags) and status logic.
// Depends on dnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnv_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dnv_pkg::stage_ctl_t            ctl,
    input  wire dnv_pkg::in_item_t              item,
    input  wire logic [dnv_pkg::CFG_DATA_W-1:0] max_label,
    input  wire logic [dnv_pkg::CFG_DATA_W-1:0] max_name,
    output dnv_pkg::status_t                    status_next
);
    import dnv_pkg::*;

    name_state_t st_reg;
    name_state_t st_next;
    name_state_t upd;
    logic [7:0]       c;
    logic [CNT_W-1:0] lim_label;
    logic [CNT_W-1:0] lim_name;

    assign c = item.name_byte;
    assign lim_label = {1'b0, max_label};
    assign lim_name  = {1'b0, max_name};

    always_comb
    begin
        upd = st_reg;
        if (item.byte_present)
        begin
            if (st_reg.name_bytes == '0 && c == CHAR_DOT)
                upd.first_was_dot = 1'b1;
            upd.name_bytes = sat_inc(st_reg.name_bytes);
            if (c[7])
            begin
                upd.label_bytes = sat_inc(st_reg.label_bytes);
                if (!c[6])
                begin
                    if (st_reg.trail_left == 2'd0)
                        upd.fatal_seen = 1'b1;
                    else
                        upd.trail_left = st_reg.trail_left - 2'd1;
                end
                else if (st_reg.trail_left != 2'd0)
                    upd.fatal_seen = 1'b1;
                else if (!c[5])
                    upd.trail_left = 2'd1;
                else if (!c[4])
                    upd.trail_left = 2'd2;
                else if (!c[3])
                    upd.trail_left = 2'd3;
                else
                    upd.fatal_seen = 1'b1;
            end
            else if (st_reg.trail_left != 2'd0)
            begin
                upd.label_bytes = sat_inc(st_reg.label_bytes);
                upd.fatal_seen = 1'b1;
            end
            else if (c == CHAR_DOT)
            begin
                if (st_reg.label_bytes == '0 || st_reg.label_bytes > lim_label)
                    upd.fatal_seen = 1'b1;
                upd.label_bytes = '0;
            end
            else
            begin
                upd.label_bytes = sat_inc(st_reg.label_bytes);
                if (!is_plain(c))
                begin
                    upd.non_rfc_seen = 1'b1;
                    if (c != CHAR_UNDERSCORE)
                        upd.bad_char_seen = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (upd.name_bytes == '0 || upd.name_bytes > lim_name)
            status_next = STATUS_INVALID;
        else if (upd.name_bytes == CNT_W'(1) && upd.first_was_dot)
            status_next = STATUS_VALID;
        else if (upd.fatal_seen || upd.label_bytes > lim_label)
            status_next = STATUS_INVALID;
        else if (upd.bad_char_seen)
            status_next = STATUS_BAD_CHAR;
        else if (upd.non_rfc_seen)
            status_next = STATUS_NON_RFC;
        else
            status_next = STATUS_VALID;
    end

    always_comb
    begin
        st_next = st_reg;
        if (ctl.step)
            st_next = item.end_of_name ? '0 : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

`default_nettype wire

// File: rtl/dnv_out_stage.sv
// Result register: holds one status until the downstream side takes it.
// Depends on dnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnv_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dnv_pkg::stage_ctl_t ctl,
    input  wire dnv_pkg::status_t    status_next,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               status,
    output logic                     out_busy
);
    import dnv_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    status_t status_reg;

    assign out_busy = vld_reg && out_stall;

    always_comb
    begin
        vld_next = vld_reg && out_stall;
        if (ctl.load_result)
            vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_result)
            status_reg <= status_next;
    end

    assign out_valid = vld_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// File: rtl/dns_name_validator_top.sv
// Top level of the DNS name validator: input stage, core, result stage, config.
// Depends on dnv_pkg, dnv_cfg_regs, dnv_in_stage, dnv_core, dnv_out_stage.
//
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------------
//  in      | in_valid / in_stall      | name_byte, byte_present, end_of_name
//  out     | out_valid / out_stall    | status
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; the result register loads a status
// as the name-ending request leaves the input register. The per-byte work is one
// compare/increment pass between the input register and the result register.
// in_stall rises only when a name-ending request waits on a stalled result.
// Reset clears limits to 63/255 and all per-name state; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_validator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     name_byte,
    input  wire logic                           byte_present,
    input  wire logic                           end_of_name,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dnv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dnv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dnv_pkg::*;

    in_item_t              in_item;
    in_item_t              item;
    stage_ctl_t            ctl;
    status_t               status_next;
    logic                  out_busy;
    logic [CFG_DATA_W-1:0] max_label;
    logic [CFG_DATA_W-1:0] max_name;

    assign in_item.name_byte = name_byte;
    assign in_item.byte_present = byte_present;
    assign in_item.end_of_name = end_of_name;

    dnv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .max_label (max_label),
        .max_name  (max_name)
    );

    dnv_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_busy (out_busy),
        .item     (item),
        .ctl      (ctl)
    );

    dnv_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .item        (item),
        .max_label   (max_label),
        .max_name    (max_name),
        .status_next (status_next)
    );

    dnv_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status_next (status_next),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_busy    (out_busy)
    );

endmodule

`default_nettype wire

// File: rtl/dnv_checker.sv
// Port-level checker for dns_name_validator_top, attached with a bind.
// Sees only the handshake and payload ports of the request and result channels.
`timescale 1ns / 1ps
`default_nettype none

module dnv_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] name_byte,
    input  wire logic       byte_present,
    input  wire logic       end_of_name,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] status
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result changed while stalled");

    // a stalled request keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=>
            in_valid && $stable({name_byte, byte_present, end_of_name}))
        else $error("request changed while stalled");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an accepted name-ending request
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && end_of_name, 2))
        else $error("result without a name-ending request");

    // nothing comes out on the first edge after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind dns_name_validator_top dnv_checker u_dnv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .name_byte    (name_byte),
    .byte_present (byte_present),
    .end_of_name  (end_of_name),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for dns_name_validator_top: a directed table, then random
// well-formed and broken names under several limit settings, checked by a local predictor.
// Depends on dnv_pkg and the RTL of dns_name_validator_top.
`timescale 1ns / 1ps

module testbench;
    import dnv_pkg::*;

    localparam int STALL_PCT = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASE_ITEMS = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_NAME_BYTES = 530;
    localparam int DIR_ROWS = 23;
    localparam int SET_ROWS = 8;

    typedef struct packed {
        logic [7:0] nbyte;
        logic       present;
        logic       last;
        logic       pin;
        status_t    want;
    } dir_row_t;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] name_byte;
    logic byte_present;
    logic end_of_name;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // directed rows may pin the expected status of the request on the bus
    logic pinned;
    status_t pinned_status;

    // predictor copy of limits and per-name state
    logic [7:0] label_limit;
    logic [7:0] name_limit;
    logic [1:0] seq_owed;
    logic [CNT_W-1:0] label_len;
    logic [CNT_W-1:0] name_len;
    logic broken;
    logic has_bad_char;
    logic off_rfc;
    logic led_with_dot;

    status_t status_q[$];
    dir_row_t dir_rows [0:DIR_ROWS-1];
    logic [7:0] label_set [0:SET_ROWS-1] = '{8'd255, 8'd1, 8'd0, 8'd63, 8'd4, 8'd20, 8'd255, 8'd10};
    logic [7:0] name_set [0:SET_ROWS-1] = '{8'd255, 8'd8, 8'd40, 8'd0, 8'd12, 8'd30, 8'd1, 8'd64};

    int errors = 0;
    int requests = 0;
    int names_done = 0;
    int settings_used = 1;
    int status_seen [0:3] = '{0, 0, 0, 0};
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    dns_name_validator_top uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CHAR_HYPHEN;
    endfunction

    task automatic forget_name();
        seq_owed = 2'd0;
        label_len = '0;
        name_len = '0;
        broken = 1'b0;
        has_bad_char = 1'b0;
        off_rfc = 1'b0;
        led_with_dot = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] c);
        if (name_len == '0 && c == CHAR_DOT)
            led_with_dot = 1'b1;
        name_len = step_count(name_len);
        if (c[7])
        begin
            label_len = step_count(label_len);
            if (!c[6])
            begin
                if (seq_owed == 2'd0)
                    broken = 1'b1;
                else
                    seq_owed = seq_owed - 2'd1;
            end
            else if (seq_owed != 2'd0)
                broken = 1'b1;
            else if (!c[5])
                seq_owed = 2'd1;
            else if (!c[4])
                seq_owed = 2'd2;
            else if (!c[3])
                seq_owed = 2'd3;
            else
                broken = 1'b1;
        end
        else if (seq_owed != 2'd0)
        begin
            label_len = step_count(label_len);
            broken = 1'b1;
        end
        else if (c == CHAR_DOT)
        begin
            if (label_len == '0 || label_len > label_limit)
                broken = 1'b1;
            label_len = '0;
        end
        else
        begin
            label_len = step_count(label_len);
            if (!is_name_char(c))
            begin
                off_rfc = 1'b1;
                if (c != CHAR_UNDERSCORE)
                    has_bad_char = 1'b1;
            end
        end
    endtask

    function automatic status_t name_verdict();
        if (name_len == '0 || name_len > name_limit)
            return STATUS_INVALID;
        if (name_len == 1 && led_with_dot)
            return STATUS_VALID;
        if (broken || label_len > label_limit)
            return STATUS_INVALID;
        if (has_bad_char)
            return STATUS_BAD_CHAR;
        if (off_rfc)
            return STATUS_NON_RFC;
        return STATUS_VALID;
    endfunction

    function automatic logic [7:0] plain_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'h61 + 8'(r);
        if (r < 52)
            return 8'h41 + 8'(r - 26);
        if (r < 62)
            return 8'h30 + 8'(r - 52);
        return CHAR_HYPHEN;
    endfunction

    function automatic byte_q_t make_name();
        byte_q_t seq;
        int kind;
        int labels;
        int len;
        int cnt;
        int pick;
        int target;
        int n;
        int edge_pct;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            len = $urandom_range(1, 6);
            repeat (len) seq.push_back(8'($urandom_range(0, 255)));
            return seq;
        end
        if (kind < 16)
        begin
            // fill up to around the name limit when it is at most 70, else a short name
            if (name_limit <= 70)
                target = int'(name_limit) - 1 + int'($urandom_range(0, 2));
            else
                target = $urandom_range(1, 12);
            if (target < 1)
                target = 1;
            len = 0;
            while (seq.size() < target)
            begin
                if (len > 0 && seq.size() < target - 1 &&
                    (len >= label_limit || $urandom_range(0, 9) == 0))
                begin
                    seq.push_back(CHAR_DOT);
                    len = 0;
                end
                else
                begin
                    seq.push_back(plain_char());
                    len++;
                end
            end
            return seq;
        end
        edge_pct = (label_limit > 40) ? 2 : 15;
        labels = $urandom_range(1, 4);
        for (int k = 0; k < labels; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < edge_pct)
                len = int'(label_limit) + int'($urandom_range(0, 1));
            else if (pick < edge_pct + 3)
                len = 0;
            else
                len = $urandom_range(1, (label_limit < 2) ? 1 : (label_limit < 10 ? label_limit : 10));
            cnt = 0;
            while (cnt < len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    seq.push_back(plain_char());
                    cnt++;
                end
                else if (pick < 90)
                begin
                    seq.push_back(CHAR_UNDERSCORE);
                    cnt++;
                end
                else if (pick < 93)
                begin
                    do
                        c = 8'($urandom_range(0, 127));
                    while (is_name_char(c) || c == CHAR_DOT || c == CHAR_UNDERSCORE);
                    seq.push_back(c);
                    cnt++;
                end
                else
                begin
                    n = $urandom_range(2, 4);
                    case (n)
                        2: seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                        3: seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                        default: seq.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                    endcase
                    repeat (n - 1) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    cnt += n;
                end
            end
            if (k < labels - 1)
                seq.push_back(CHAR_DOT);
        end
        if ($urandom_range(0, 99) < 15)
            seq.push_back(CHAR_DOT);
        if (seq.size() > 0 && $urandom_range(0, 99) < 5)
            seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
        return seq;
    endfunction

    task automatic offer(input logic [7:0] b, input logic present, input logic last,
                         input logic pin, input status_t want);
        if (!calm && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid = 1'b1;
        name_byte = b;
        byte_present = present;
        end_of_name = last;
        pinned = pin;
        pinned_status = want;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (present || last)
            requests++;
    endtask

    task automatic send_name(input byte_q_t seq, input bit empty_end);
        foreach (seq[i])
        begin
            if ($urandom_range(0, 99) < 3)
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, STATUS_VALID);
            offer(seq[i], 1'b1, !empty_end && i == seq.size() - 1, 1'b0, STATUS_VALID);
        end
        if (empty_end || seq.size() == 0)
            offer(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, STATUS_VALID);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_MAX_LABEL)
            label_limit = val;
        else if (idx == CFG_MAX_NAME)
            name_limit = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (byte_present)
                absorb_byte(name_byte);
            if (end_of_name)
            begin
                status_q.push_back(pinned ? pinned_status : name_verdict());
                forget_name();
                names_done++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: status %0d with no request pending", $time, status);
                errors++;
            end
            else
            begin
                if (status !== status_q[0])
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, status_q[0], status);
                    errors++;
                end
                else
                    status_seen[status]++;
                void'(status_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("dns_name_validator_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall = !calm && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    initial
    begin : stimulus
        byte_q_t seq;
        int phase;
        int base;
        int phase_start;
        rst_n = 1'b0;
        in_valid = 1'b0;
        name_byte = 8'h00;
        byte_present = 1'b0;
        end_of_name = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pinned = 1'b0;
        pinned_status = STATUS_VALID;
        label_limit = MAX_LABEL_RST;
        name_limit = MAX_NAME_RST;
        forget_name();

        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, STATUS_INVALID},     // empty name
            '{8'hA5, 1'b0, 1'b0, 1'b0, STATUS_VALID},       // idle request
            '{CHAR_DOT, 1'b1, 1'b1, 1'b1, STATUS_VALID},    // lone dot
            '{8'h61, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{CHAR_UNDERSCORE, 1'b1, 1'b1, 1'b1, STATUS_NON_RFC},
            '{8'h00, 1'b1, 1'b1, 1'b1, STATUS_BAD_CHAR},    // NUL
            '{8'hFF, 1'b1, 1'b1, 1'b1, STATUS_INVALID},     // 11111xxx lead
            '{8'h5A, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{8'h30, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{CHAR_DOT, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{8'h00, 1'b0, 1'b1, 1'b0, STATUS_VALID},       // end marker after trailing dot
            '{CHAR_DOT, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{CHAR_DOT, 1'b1, 1'b1, 1'b1, STATUS_INVALID},  // empty labels
            '{8'hC3, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{8'hA9, 1'b1, 1'b1, 1'b0, STATUS_VALID},
            '{8'h80, 1'b1, 1'b1, 1'b1, STATUS_INVALID},     // stray trail byte
            '{8'hE2, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{8'h61, 1'b1, 1'b1, 1'b1, STATUS_INVALID},     // ASCII inside sequence
            '{8'hF0, 1'b1, 1'b1, 1'b0, STATUS_VALID},       // sequence open at end
            '{8'h7F, 1'b1, 1'b1, 1'b1, STATUS_BAD_CHAR},
            '{CHAR_HYPHEN, 1'b1, 1'b0, 1'b0, STATUS_VALID},
            '{8'h7A, 1'b1, 1'b1, 1'b0, STATUS_VALID},
            '{8'h39, 1'b1, 1'b1, 1'b0, STATUS_VALID}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].nbyte, dir_rows[i].present, dir_rows[i].last,
                  dir_rows[i].pin, dir_rows[i].want);

        phase = 0;
        base = requests;
        while (requests - base < RANDOM_ITEMS)
        begin
            if (phase > 0)
            begin
                settle();
                if (phase <= SET_ROWS)
                begin
                    write_reg(CFG_MAX_LABEL, label_set[phase - 1]);
                    write_reg(CFG_MAX_NAME, name_set[phase - 1]);
                end
                else
                begin
                    write_reg(CFG_MAX_LABEL, ($urandom_range(0, 4) == 0) ? 8'd255 :
                              8'($urandom_range(1, 40)));
                    write_reg(CFG_MAX_NAME, ($urandom_range(0, 4) == 0) ? 8'd255 :
                              8'($urandom_range(1, 80)));
                end
                if (phase % 3 == 0)
                    write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
                settings_used++;
            end
            calm = (phase == 4);
            if (phase == 2)
                hold_req = 1'b1;
            if (phase == 1)
            begin
                // counters must saturate, not wrap
                seq.delete();
                repeat (LONG_NAME_BYTES) seq.push_back(plain_char());
                send_name(seq, 1'b0);
            end
            phase_start = requests;
            while (requests - phase_start < PHASE_ITEMS)
            begin
                seq = make_name();
                send_name(seq, $urandom_range(0, 9) == 0);
            end
            phase++;
        end
        calm = 1'b0;
        settle();

        $display("Checked %0d names from %0d requests under %0d limit settings.",
                 names_done, requests, settings_used);
        $display("Statuses: %0d valid, %0d non-RFC, %0d bad character, %0d invalid.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && status_q.size() == 0)
            $display("dns_name_validator_top regression: pass");
        else
            $display("dns_name_validator_top regression: fail");
        $finish;
    end

endmodule

// File: dns_name_validator_top.f
rtl/dnv_pkg.sv
rtl/dnv_cfg_regs.sv
rtl/dnv_in_stage.sv
rtl/dnv_core.sv
rtl/dnv_out_stage.sv
rtl/dns_name_validator_top.sv
rtl/dnv_checker.sv
test/testbench.sv
